### hw/rtl/lcdws_pkg.sv
package lcdws_pkg;

    localparam int FIFO_DEPTH = 2;

    typedef enum logic [2:0] {
        MODE_INIT = 3'd0,
        MODE_CMD  = 3'd1,
        MODE_CHAR = 3'd2,
        MODE_POS  = 3'd3,
        MODE_NUM  = 3'd4
    } req_mode_t;

    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    localparam logic [7:0] LINE0_BASE  = 8'h80;
    localparam logic [7:0] LINE1_BASE  = 8'hC0;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] NIBBLE_MASK = 8'hF0;

    // Number of transfers minus one for the init list in each bus width.
    localparam logic [3:0] INIT8_LAST_STEP = 4'd3;
    localparam logic [3:0] INIT4_LAST_STEP = 4'd13;

    // One queued job: either the init list or up to three bytes.
    typedef struct packed {
        logic            is_init;
        logic            rs;
        logic [1:0]      nbytes;
        logic [2:0][7:0] bytes;
    } job_t;

    function automatic logic [7:0] init_cmd(input logic bw4, input logic [2:0] idx);
        logic [7:0] cmd;
        cmd = 8'h00;
        if (bw4) begin
            unique case (idx)
                3'd0: cmd = 8'h33;
                3'd1: cmd = 8'h32;
                3'd2: cmd = 8'h28;
                3'd3: cmd = 8'h0C;
                3'd4: cmd = 8'h01;
                3'd5: cmd = 8'h06;
                3'd6: cmd = 8'h02;
                default: cmd = 8'h00;
            endcase
        end else begin
            unique case (idx)
                3'd0: cmd = 8'h38;
                3'd1: cmd = 8'h0C;
                3'd2: cmd = 8'h01;
                3'd3: cmd = 8'h06;
                default: cmd = 8'h00;
            endcase
        end
        return cmd;
    endfunction

endpackage

### hw/rtl/lcdws_front.sv
module lcdws_front (
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [2:0]        s_tuser,
    input  logic [15:0]       s_tdata,
    output logic              push,
    output lcdws_pkg::job_t   job
);

    logic [7:0] value;
    logic [7:0] line;
    logic       keep;
    logic [1:0] hundreds;
    logic [7:0] rem8;
    logic [6:0] rem;
    logic [14:0] prod;
    logic [3:0] tens;
    logic [6:0] ones;

    assign value = s_tdata[7:0];
    assign line  = s_tdata[15:8];

    // Digits: hundreds by compare, tens by reciprocal multiply (exact below 1029).
    always_comb begin
        if (value >= 8'd200) begin
            hundreds = 2'd2;
            rem8     = value - 8'd200;
        end else if (value >= 8'd100) begin
            hundreds = 2'd1;
            rem8     = value - 8'd100;
        end else begin
            hundreds = 2'd0;
            rem8     = value;
        end
        rem  = rem8[6:0];
        prod = {8'd0, rem} * 15'd205;
        tens = prod[14:11];
        ones = rem - {tens, 3'b000} - {2'b00, tens, 1'b0};
    end

    always_comb begin
        keep        = 1'b1;
        job.is_init = 1'b0;
        job.rs      = lcdws_pkg::RS_CMD;
        job.nbytes  = 2'd1;
        job.bytes   = '0;
        unique case (s_tuser)
            lcdws_pkg::MODE_INIT: begin
                job.is_init = 1'b1;
            end
            lcdws_pkg::MODE_CMD: begin
                job.bytes[0] = value;
            end
            lcdws_pkg::MODE_CHAR: begin
                job.rs       = lcdws_pkg::RS_DATA;
                job.bytes[0] = value;
            end
            lcdws_pkg::MODE_POS: begin
                if (line == 8'd0) begin
                    job.bytes[0] = lcdws_pkg::LINE0_BASE + value;
                end else if (line == 8'd1) begin
                    job.bytes[0] = lcdws_pkg::LINE1_BASE + value;
                end else begin
                    keep = 1'b0;
                end
            end
            lcdws_pkg::MODE_NUM: begin
                job.rs       = lcdws_pkg::RS_DATA;
                job.nbytes   = 2'd3;
                job.bytes[0] = lcdws_pkg::ASCII_ZERO + {6'd0, hundreds};
                job.bytes[1] = lcdws_pkg::ASCII_ZERO + {4'd0, tens};
                job.bytes[2] = lcdws_pkg::ASCII_ZERO + {1'b0, ones};
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // Requests that cause no transfer are taken and dropped here.
    assign push = s_tvalid && s_tready && keep;

endmodule

### hw/rtl/lcdws_fifo.sv
module lcdws_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output logic [WIDTH-1:0] head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/lcdws_back.sv
module lcdws_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            bus_width_sel,
    input  logic            job_valid,
    input  lcdws_pkg::job_t job,
    output logic            job_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,   // bus_value[7:0]
    output logic            m_tuser,   // reg_select
    output logic            m_tlast
);

    logic [3:0] step_reg, step_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg;
    logic       m_tuser_reg;
    logic       m_tlast_reg;
    logic       advance;
    logic [3:0] last_step;
    logic [2:0] byte_idx;
    logic [7:0] cur_byte;
    logic [7:0] bus;
    logic       is_last;

    assign advance = job_valid && (!m_tvalid_reg || m_tready);

    always_comb begin
        if (job.is_init) begin
            last_step = bus_width_sel ? lcdws_pkg::INIT4_LAST_STEP
                                      : lcdws_pkg::INIT8_LAST_STEP;
        end else if (bus_width_sel) begin
            last_step = {1'b0, job.nbytes, 1'b0} - 4'd1;
        end else begin
            last_step = {2'b00, job.nbytes} - 4'd1;
        end

        // In nibble mode two transfers share one byte.
        byte_idx = bus_width_sel ? step_reg[3:1] : step_reg[2:0];
        cur_byte = job.is_init ? lcdws_pkg::init_cmd(bus_width_sel, byte_idx)
                               : job.bytes[byte_idx[1:0]];
        if (bus_width_sel) begin
            bus = step_reg[0] ? {cur_byte[3:0], 4'h0}
                              : (cur_byte & lcdws_pkg::NIBBLE_MASK);
        end else begin
            bus = cur_byte;
        end
        is_last = (step_reg == last_step);
    end

    assign job_pop = advance && is_last;

    always_comb begin
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg;
        if (advance) begin
            step_next     = is_last ? 4'd0 : step_reg + 4'd1;
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= bus;
            m_tuser_reg <= job.rs;
            m_tlast_reg <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### hw/rtl/char_lcd_write_sequencer.sv
// Character LCD write sequencer. Each request on the s_ channel becomes the
// ordered list of bus transfers for an HD44780-style display, one transfer per
// beat on the m_ channel, with tlast on the final transfer of the request.
// cfg_we/cfg_wdata set the bus width (0 for 8-bit, 1 for 4-bit nibbles on the
// upper data lines); the user must write them only while the block is idle, and the
// block itself does not enforce this. The output register issues one transfer per
// cycle while m_tready is high. A request has as many transfers as follows: init 4 (8-bit) or 14 (4-bit), a
// command, character or cursor position 1 or 2, a number 3 or 6. A small job
// queue lets the next request be taken while the current one is still being
// sent. Position requests for a line other than 0 or 1 and unused mode codes
// are taken and produce nothing.
module char_lcd_write_sequencer #(
    parameter int FIFO_DEPTH = lcdws_pkg::FIFO_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,   // bus_width_sel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // value[7:0], line[15:8]
    input  logic [2:0]  s_tuser,     // mode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // bus_value[7:0]
    output logic        m_tuser,     // reg_select
    output logic        m_tlast
);

    localparam int JOB_W = $bits(lcdws_pkg::job_t);

    logic            bus_width_sel_reg;
    logic            push;
    lcdws_pkg::job_t front_job;
    lcdws_pkg::job_t head_job;
    logic [JOB_W-1:0] head_bits;
    logic            fifo_full;
    logic            fifo_not_empty;
    logic            job_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bus_width_sel_reg <= 1'b0;
        end else if (cfg_we) begin
            bus_width_sel_reg <= cfg_wdata;
        end
    end

    assign s_tready = !fifo_full;

    lcdws_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .push     (push),
        .job      (front_job)
    );

    lcdws_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_job),
        .pop       (job_pop),
        .full      (fifo_full),
        .not_empty (fifo_not_empty),
        .head      (head_bits)
    );

    assign head_job = lcdws_pkg::job_t'(head_bits);

    lcdws_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .bus_width_sel (bus_width_sel_reg),
        .job_valid     (fifo_not_empty),
        .job           (head_job),
        .job_pop       (job_pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast)
    );

endmodule

### hw/rtl/lcdws_checker.sv
module lcdws_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_we,
    input logic        cfg_wdata,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    logic bw4_reg;

    // Shadow of the bus width register, rebuilt from the write port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bw4_reg <= 1'b0;
        end else if (cfg_we) begin
            bw4_reg <= cfg_wdata;
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output changed while stalled");

    a_nibble_low_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && bw4_reg |-> m_tdata[3:0] == 4'h0)
        else $error("low data lines not zero in nibble mode");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // A request is registered into the queue and then into the output register before
    // its first transfer shows, so an idle output with no request in this cycle or the previous one stays idle.
    a_no_output_from_nothing: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && !(s_tvalid && s_tready) && !$past(s_tvalid && s_tready)
            |=> !m_tvalid)
        else $error("transfer appeared with no request pending");

endmodule

bind char_lcd_write_sequencer lcdws_checker u_lcdws_checker (.*);
